>>> src/ipt_pkg.sv
`timescale 1ns / 1ps

package ipt_pkg;

   localparam int unsigned NUM_CH    = 4;
   localparam int unsigned CNT_W     = 14;
   localparam int unsigned SECS_W    = 10;
   localparam int unsigned CSR_IDX_W = 3;

   // Channel numbers
   localparam int unsigned CH_DIM   = 0;
   localparam int unsigned CH_OFF   = 1;
   localparam int unsigned CH_OVL   = 2;
   localparam int unsigned CH_CLEAR = 3;

   localparam logic [CNT_W-1:0] SENSOR_LOAD = CNT_W'(25);
   localparam logic [CNT_W-1:0] CLEAR_LOAD  = CNT_W'(30);
   localparam logic [CNT_W-1:0] WARN_LEVEL  = CNT_W'(30);
   localparam logic [CNT_W-1:0] SOON_LEVEL  = CNT_W'(10);
   localparam logic [CNT_W-1:0] NOW_LEVEL   = CNT_W'(1);
   localparam logic [CNT_W-1:0] RESET_LOAD  = CNT_W'(50);

   typedef enum logic [2:0] {
      FUNC_TICK       = 3'd0,
      FUNC_WAKEUP     = 3'd1,
      FUNC_FORCE_NOW  = 3'd2,
      FUNC_FORCE_SOON = 3'd3,
      FUNC_INFO_KEY   = 3'd4
   } func_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DIM_AFTER     = 3'd0,
      CSR_OFF_AFTER     = 3'd1,
      CSR_OVL_AFTER     = 3'd2,
      CSR_ALLOW_REC     = 3'd3,
      CSR_CLEAR_IDLE    = 3'd4,
      CSR_SENSOR_WAKE   = 3'd5,
      CSR_SHORTCUT_KEY  = 3'd6
   } csr_idx_type;

   typedef struct packed {
      logic [SECS_W-1:0] dim_after_s;
      logic [SECS_W-1:0] off_after_s;
      logic [SECS_W-1:0] overlay_off_after_s;
      logic              allow_while_recording;
      logic              clear_overlay_when_idle;
      logic              sensor_wakeup_enable;
      logic              shortcut_key_enable;
   } cfg_type;

   typedef struct packed {
      logic [2:0] func;
      logic       reason_full;
      logic       shutdown;
      logic       recording;
      logic       host_connected;
      logic       view_idle;
      logic       half_shutter;
      logic       menu_shown;
      logic       screen_on;
      logic       sensor_covered;
      logic       live_view;
      logic       fake_event;
   } item_type;

   typedef struct packed {
      logic [NUM_CH-1:0][CNT_W-1:0] cnt;
      logic [NUM_CH-1:0]            nonzero;
      logic                         sensor_prev;
      logic                         warn_dirty;
   } timer_state_type;

   typedef struct packed {
      logic [NUM_CH-1:0] enter_mask;
      logic [NUM_CH-1:0] exit_mask;
      logic              warning_show;
      logic              warning_hide;
      logic              powersave_active;
      logic              key_consumed;
      logic              led_blink;
   } result_type;

endpackage

>>> src/idle_powersave_timers.sv
`timescale 1ns / 1ps

// Idle powersave timers: four idle countdowns in tenths of a second
// (dim, display off, overlay draw off, clear overlay).
// Channels:
//   req_*  : one item per transfer; req_tuser carries func, req_tdata the
//            status flags of that moment.
//   rsp_*  : exactly one result transfer per request transfer, in order.
//   csr_*  : register writes, always ready; the user must write only while
//            no item is in flight, which the block does not enforce.
// Path: input register, then result register; the countdown state is
// updated at the same edge the result is registered.
// Throughput: one item per cycle when not stalled. All four channel
// visits are unrolled in the step logic between the two registers, so
// nothing iterates.
// Stall: when rsp_tready is low the result register holds and the input
// register still takes one more item; then req_tready drops until the
// result is taken.
// Reset: synchronous, active high. Counts load 50, all channels count as
// nonzero, registers take their defaults (sensor wakeup enabled).
module idle_powersave_timers (
   input  logic                            clock,
   input  logic                            reset,
   // slave side
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [2:0]                      req_tuser,  // func
   // [0] reason_full [1] shutdown [2] recording [3] host_connected
   // [4] view_idle [5] half_shutter [6] menu_shown [7] screen_on
   // [8] sensor_covered [9] live_view [10] fake_event [15:11] zero
   input  logic [15:0]                     req_tdata,
   // master side
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // [3:0] enter_mask [7:4] exit_mask [8] warning_show [9] warning_hide
   // [10] powersave_active [11] key_consumed [12] led_blink [15:13] zero
   output logic [15:0]                     rsp_tdata,
   // register write port
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [ipt_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [ipt_pkg::SECS_W-1:0]      csr_data
);

   ipt_pkg::cfg_type         cfg_ff;
   ipt_pkg::item_type        item_ff;
   logic                     item_valid_ff;
   ipt_pkg::timer_state_type state_ff;
   ipt_pkg::timer_state_type state_in;
   ipt_pkg::result_type      result_in;
   ipt_pkg::result_type      result_ff;
   logic                     rsp_valid_ff;
   logic                     advance;
   ipt_pkg::item_type        item_in;

   // the pipeline moves whenever the result register is free or being drained
   assign advance    = ~rsp_valid_ff | rsp_tready;
   assign req_tready = ~item_valid_ff | advance;
   assign csr_ready  = 1'b1;

   assign item_in = '{
      func:           req_tuser,
      reason_full:    req_tdata[0],
      shutdown:       req_tdata[1],
      recording:      req_tdata[2],
      host_connected: req_tdata[3],
      view_idle:      req_tdata[4],
      half_shutter:   req_tdata[5],
      menu_shown:     req_tdata[6],
      screen_on:      req_tdata[7],
      sensor_covered: req_tdata[8],
      live_view:      req_tdata[9],
      fake_event:     req_tdata[10]
   };

   // register file
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{
            dim_after_s:             '0,
            off_after_s:             '0,
            overlay_off_after_s:     '0,
            allow_while_recording:   1'b0,
            clear_overlay_when_idle: 1'b0,
            sensor_wakeup_enable:    1'b1,
            shortcut_key_enable:     1'b0
         };
      end else if (csr_valid && csr_ready) begin
         unique case (ipt_pkg::csr_idx_type'(csr_index))
            ipt_pkg::CSR_DIM_AFTER:    cfg_ff.dim_after_s             <= csr_data;
            ipt_pkg::CSR_OFF_AFTER:    cfg_ff.off_after_s             <= csr_data;
            ipt_pkg::CSR_OVL_AFTER:    cfg_ff.overlay_off_after_s     <= csr_data;
            ipt_pkg::CSR_ALLOW_REC:    cfg_ff.allow_while_recording   <= csr_data[0];
            ipt_pkg::CSR_CLEAR_IDLE:   cfg_ff.clear_overlay_when_idle <= csr_data[0];
            ipt_pkg::CSR_SENSOR_WAKE:  cfg_ff.sensor_wakeup_enable    <= csr_data[0];
            ipt_pkg::CSR_SHORTCUT_KEY: cfg_ff.shortcut_key_enable     <= csr_data[0];
            default: begin
            end
         endcase
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else if (req_tready) begin
         item_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         item_ff <= item_in;
      end
   end

   ipt_step u_step (
      .cfg_i    (cfg_ff),
      .item_i   (item_ff),
      .state_i  (state_ff),
      .state_o  (state_in),
      .result_o (result_in)
   );

   // countdown state commits when the item moves into the result register
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int ch = 0; ch < ipt_pkg::NUM_CH; ch++) begin
            state_ff.cnt[ch] <= ipt_pkg::RESET_LOAD;
         end
         state_ff.nonzero     <= '1;
         state_ff.sensor_prev <= 1'b0;
         state_ff.warn_dirty  <= 1'b0;
      end else if (item_valid_ff && advance) begin
         state_ff <= state_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= item_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && item_valid_ff) begin
         result_ff <= result_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000,
                        result_ff.led_blink,
                        result_ff.key_consumed,
                        result_ff.powersave_active,
                        result_ff.warning_hide,
                        result_ff.warning_show,
                        result_ff.exit_mask,
                        result_ff.enter_mask};

endmodule

>>> src/ipt_step.sv
`timescale 1ns / 1ps

// Next-state and result logic for one item, all four channels in order.
module ipt_step (
   input  ipt_pkg::cfg_type         cfg_i,
   input  ipt_pkg::item_type        item_i,
   input  ipt_pkg::timer_state_type state_i,
   output ipt_pkg::timer_state_type state_o,
   output ipt_pkg::result_type      result_o
);

   logic                       sensor_act;
   logic                       idle;
   logic [ipt_pkg::NUM_CH-1:0] ch_en;
   logic [2:0][ipt_pkg::CNT_W-1:0] load;
   logic                       ps_before;
   logic                       key_ok;
   ipt_pkg::timer_state_type   st;
   ipt_pkg::result_type        res;

   assign sensor_act = cfg_i.sensor_wakeup_enable & item_i.sensor_covered;
   assign idle = (item_i.view_idle & ~item_i.half_shutter & ~item_i.menu_shown)
               | ~item_i.screen_on;

   assign ch_en[ipt_pkg::CH_DIM]   = cfg_i.dim_after_s != '0;
   assign ch_en[ipt_pkg::CH_OFF]   = cfg_i.off_after_s != '0;
   assign ch_en[ipt_pkg::CH_OVL]   = cfg_i.overlay_off_after_s != '0;
   assign ch_en[ipt_pkg::CH_CLEAR] = cfg_i.clear_overlay_when_idle;

   // seconds * 10 as two shifted adds
   function automatic logic [ipt_pkg::CNT_W-1:0] times_ten(
      input logic [ipt_pkg::SECS_W-1:0] s
   );
      return ipt_pkg::CNT_W'({s, 3'b000}) + ipt_pkg::CNT_W'({s, 1'b0});
   endfunction

   assign load[ipt_pkg::CH_DIM] = sensor_act ? ipt_pkg::SENSOR_LOAD
                                             : times_ten(cfg_i.dim_after_s);
   assign load[ipt_pkg::CH_OFF] = sensor_act ? ipt_pkg::SENSOR_LOAD
                                             : times_ten(cfg_i.off_after_s);
   assign load[ipt_pkg::CH_OVL] = sensor_act ? ipt_pkg::SENSOR_LOAD
                                             : times_ten(cfg_i.overlay_off_after_s);

   assign ps_before = |(ch_en[2:0] & ~state_i.nonzero[2:0]);
   assign key_ok = cfg_i.shortcut_key_enable & item_i.live_view & (|ch_en[2:0])
                 & ~item_i.fake_event & ~item_i.menu_shown;

   always_comb begin
      st  = state_i;
      res = '0;
      unique case (ipt_pkg::func_type'(item_i.func))
         ipt_pkg::FUNC_TICK: begin
            if (!item_i.shutdown) begin
               if (item_i.recording && !cfg_i.allow_while_recording) begin
                  st.cnt[2:0] = load;
               end
               if (item_i.host_connected) begin
                  st.cnt[2:0] = load;
                  st.cnt[ipt_pkg::CH_CLEAR] = ipt_pkg::CLEAR_LOAD;
               end
            end
            for (int ch = 0; ch < ipt_pkg::NUM_CH; ch++) begin
               if (ch_en[ch] && !item_i.shutdown) begin
                  if (idle) begin
                     if (st.cnt[ch] != '0) begin
                        st.cnt[ch] = st.cnt[ch] - ipt_pkg::CNT_W'(1);
                     end
                  end else begin
                     st.cnt[2:0] = load;
                     st.cnt[ipt_pkg::CH_CLEAR] = ipt_pkg::CLEAR_LOAD;
                  end
                  // sensor edge reloads everything
                  if (sensor_act != st.sensor_prev) begin
                     st.cnt[2:0] = load;
                     st.cnt[ipt_pkg::CH_CLEAR] = ipt_pkg::CLEAR_LOAD;
                  end
                  st.sensor_prev = sensor_act;
                  if (st.nonzero[ch] && st.cnt[ch] == '0) begin
                     res.enter_mask[ch] = 1'b1;
                  end else if (!st.nonzero[ch] && st.cnt[ch] != '0) begin
                     res.exit_mask[ch] = 1'b1;
                  end
                  st.nonzero[ch] = st.cnt[ch] != '0;
               end
               // warning check sits right after the display-off visit
               if (ch == ipt_pkg::CH_OFF && ch_en[ch]) begin
                  if (st.cnt[ch] == ipt_pkg::WARN_LEVEL) begin
                     res.warning_show = 1'b1;
                     st.warn_dirty    = 1'b1;
                  end else if (st.warn_dirty && st.cnt[ch] > ipt_pkg::WARN_LEVEL) begin
                     res.warning_hide = 1'b1;
                     st.warn_dirty    = 1'b0;
                  end
               end
            end
         end
         ipt_pkg::FUNC_WAKEUP: begin
            if (!item_i.shutdown) begin
               st.cnt[2:0] = load;
               if (item_i.reason_full) begin
                  st.cnt[ipt_pkg::CH_CLEAR] = ipt_pkg::CLEAR_LOAD;
               end
            end
         end
         ipt_pkg::FUNC_FORCE_NOW: begin
            for (int ch = 0; ch < 3; ch++) begin
               if (st.cnt[ch] > ipt_pkg::NOW_LEVEL) st.cnt[ch] = ipt_pkg::NOW_LEVEL;
            end
         end
         ipt_pkg::FUNC_FORCE_SOON: begin
            for (int ch = 0; ch < 3; ch++) begin
               if (st.cnt[ch] > ipt_pkg::SOON_LEVEL) st.cnt[ch] = ipt_pkg::SOON_LEVEL;
            end
         end
         ipt_pkg::FUNC_INFO_KEY: begin
            if (key_ok) begin
               res.key_consumed = 1'b1;
               if (!ps_before) begin
                  res.led_blink = 1'b1;
                  for (int ch = 0; ch < 3; ch++) begin
                     if (st.cnt[ch] > ipt_pkg::NOW_LEVEL) st.cnt[ch] = ipt_pkg::NOW_LEVEL;
                  end
               end
            end
         end
         default: begin
         end
      endcase
      res.powersave_active = |(ch_en[2:0] & ~st.nonzero[2:0]);
   end

   assign state_o  = st;
   assign result_o = res;

endmodule

>>> src/ipt_checker.sv
`timescale 1ns / 1ps

module ipt_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [15:0]                     rsp_tdata
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   // a channel either reaches zero or leaves it in one tick, never both
   a_enter_exit: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[3:0] & rsp_tdata[7:4]) == 4'b0000)
      else $error("enter and exit on the same channel");

   a_warn: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[8] && rsp_tdata[9]))
      else $error("warning shown and hidden together");

   // blink only when the key was taken and powersave was off
   a_blink: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[12] |-> rsp_tdata[11] && !rsp_tdata[10])
      else $error("led blink without consumed key");

endmodule

bind idle_powersave_timers ipt_checker u_ipt_checker (.*);
